// File: sv/utf8v_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and constants of the utf-8 string validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  // depth of the queue between the classifier and the checker, and of the
  // verdict queue
  localparam int unsigned QueueDepth = 2;

  // code point bits held while decoding: one lead bit plus five groups of six
  localparam int unsigned CpW = 31;

  // how a byte reads when it stands where a lead byte is expected
  typedef enum logic [1:0] {
    LeadNul,
    LeadAscii,
    LeadMulti,
    LeadBad
  } lead_e;

  // one classified byte as it travels from the classifier to the checker
  typedef struct packed {
    logic       has_byte;
    logic       is_last;
    lead_e      lead;
    logic [2:0] lead_len;
    logic [4:0] lead_bits;
    logic       cont_ok;
    logic [5:0] cont_bits;
  } item_t;

  // checker status seen by the top level
  typedef struct packed {
    logic failed;
    logic pending_zero;
    logic idle;
  } back_status_t;

endpackage : utf8v_pkg
`default_nettype wire

// File: sv/utf8v_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8v_fifo
// Small first-word-fall-through queue with full and empty flags.
// ----------------------------------------------------------------------------
module utf8v_fifo #(
  parameter int unsigned Depth = 2,
  parameter type         T     = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire T     data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          data_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T                  mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule : utf8v_fifo
`default_nettype wire

// File: sv/utf8v_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8v_front
// Byte classifier: reads each byte both as a lead byte and as a continuation
// byte so the checker only has to pick one.
// ----------------------------------------------------------------------------
module utf8v_front (
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           has_byte_i,
  input  wire logic           is_last_i,
  output utf8v_pkg::item_t    item_o
);

  import utf8v_pkg::*;

  always_comb begin
    item_o           = '0;
    item_o.has_byte  = has_byte_i;
    item_o.is_last   = is_last_i;
    item_o.cont_ok   = (data_byte_i[7:6] == 2'b10);
    item_o.cont_bits = data_byte_i[5:0];
    item_o.lead      = LeadBad;
    item_o.lead_len  = 3'd1;
    item_o.lead_bits = '0;
    unique case (data_byte_i) inside
      8'h00: begin
        item_o.lead = LeadNul;
      end
      [8'h01:8'h7f]: begin
        item_o.lead = LeadAscii;
      end
      8'b110?????: begin
        item_o.lead      = LeadMulti;
        item_o.lead_len  = 3'd2;
        item_o.lead_bits = data_byte_i[4:0];
      end
      8'b1110????: begin
        item_o.lead      = LeadMulti;
        item_o.lead_len  = 3'd3;
        item_o.lead_bits = {1'b0, data_byte_i[3:0]};
      end
      8'b11110???: begin
        item_o.lead      = LeadMulti;
        item_o.lead_len  = 3'd4;
        item_o.lead_bits = {2'b00, data_byte_i[2:0]};
      end
      8'b111110??: begin
        item_o.lead      = LeadMulti;
        item_o.lead_len  = 3'd5;
        item_o.lead_bits = {3'b000, data_byte_i[1:0]};
      end
      8'b1111110?: begin
        item_o.lead      = LeadMulti;
        item_o.lead_len  = 3'd6;
        item_o.lead_bits = {4'b0000, data_byte_i[0]};
      end
      default: begin
        // stray continuation bytes and 0xfe / 0xff
        item_o.lead = LeadBad;
      end
    endcase
  end

endmodule : utf8v_front
`default_nettype wire

// File: sv/utf8v_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8v_back
// Sequence checker: tracks pending continuation bytes, assembles the code
// point and checks length, range and surrogates; gives the verdict at the
// end mark.
// ----------------------------------------------------------------------------
module utf8v_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire utf8v_pkg::item_t     item_i,
  input  wire logic                 item_valid_i,
  output logic                      item_pop_o,
  input  wire logic                 res_full_i,
  output logic                      res_push_o,
  output logic                      res_ok_o,
  output utf8v_pkg::back_status_t   status_o
);

  import utf8v_pkg::*;

  localparam logic [19:0] SurrogateTag = 20'h0001b;  // 0xd800 >> 11

  logic           failed_q, failed_d;
  logic [2:0]     pending_q, pending_d;
  logic [2:0]     seq_len_q, seq_len_d;
  logic [CpW-1:0] cp_q, cp_d;
  logic [CpW-1:0] cp_cat;
  logic [2:0]     pending_dec;
  logic [2:0]     min_len;
  logic           scalar_ok;

  // a verdict needs room in the result queue, other items go straight on
  assign item_pop_o = item_valid_i && (!item_i.is_last || !res_full_i);
  assign res_push_o = item_pop_o && item_i.is_last;

  assign cp_cat      = {cp_q[CpW-7:0], item_i.cont_bits};
  assign pending_dec = pending_q - 3'd1;
  assign scalar_ok   = (cp_cat < CpW'(32'h0011_0000)) && (cp_cat[CpW-1:11] != SurrogateTag);

  always_comb begin
    if (cp_cat < CpW'(32'h0000_0080)) begin
      min_len = 3'd1;
    end else if (cp_cat < CpW'(32'h0000_0800)) begin
      min_len = 3'd2;
    end else if (cp_cat < CpW'(32'h0001_0000)) begin
      min_len = 3'd3;
    end else if (cp_cat < CpW'(32'h0020_0000)) begin
      min_len = 3'd4;
    end else if (cp_cat < CpW'(32'h0400_0000)) begin
      min_len = 3'd5;
    end else begin
      min_len = 3'd6;
    end
  end

  always_comb begin
    failed_d  = failed_q;
    pending_d = pending_q;
    seq_len_d = seq_len_q;
    cp_d      = cp_q;
    if (item_i.has_byte && !failed_q) begin
      if (pending_q == '0) begin
        unique case (item_i.lead)
          LeadNul, LeadBad: begin
            failed_d = 1'b1;
          end
          LeadAscii: begin
          end
          LeadMulti: begin
            seq_len_d = item_i.lead_len;
            pending_d = item_i.lead_len - 3'd1;
            cp_d      = CpW'(item_i.lead_bits);
          end
          default: begin
            failed_d = 1'b1;
          end
        endcase
      end else if (!item_i.cont_ok) begin
        failed_d = 1'b1;
      end else begin
        pending_d = pending_dec;
        cp_d      = cp_cat;
        if (pending_dec == '0) begin
          if (min_len != seq_len_q || !scalar_ok) begin
            failed_d = 1'b1;
          end
          seq_len_d = '0;
          cp_d      = '0;
        end
      end
    end
    res_ok_o = !failed_d && (pending_d == '0);
    if (item_i.is_last) begin
      failed_d  = 1'b0;
      pending_d = '0;
      seq_len_d = '0;
      cp_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      failed_q  <= 1'b0;
      pending_q <= '0;
      seq_len_q <= '0;
      cp_q      <= '0;
    end else if (item_pop_o) begin
      failed_q  <= failed_d;
      pending_q <= pending_d;
      seq_len_q <= seq_len_d;
      cp_q      <= cp_d;
    end
  end

  assign status_o.failed       = failed_q;
  assign status_o.pending_zero = (pending_q == '0);
  assign status_o.idle         = !failed_q && (pending_q == '0) && (seq_len_q == '0)
                                 && (cp_q == '0);

endmodule : utf8v_back
`default_nettype wire

// File: sv/utf8_string_validator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_string_validator_top
// UTF-8 string validator: one byte per transaction, one verdict per string.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   input     in         push_i / full_o      data_byte_i, has_byte_i, is_last_i
//   result    out        pop_i / empty_o      string_ok_o
//
// one byte per cycle sustained unless the result side stalls at an end mark;
// each byte is registered in the input queue, each verdict in the result queue.
// the checker state update (decode, shift and range compare) sets the rate.
// reset clears the queues and the checker state; no clearing pass.
// a stalled result side holds the checker only at an end mark; the input
// queue keeps taking bytes until it fills.
// ----------------------------------------------------------------------------
module utf8_string_validator_top #(
  parameter int unsigned QUEUE_DEPTH = utf8v_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       has_byte_i,
  input  wire logic       is_last_i,
  output logic            empty_o,
  input  wire logic       pop_i,
  output logic            string_ok_o
);

  import utf8v_pkg::*;

  item_t        in_item;
  item_t        q_item;
  logic         q_empty;
  logic         q_pop;
  logic         res_full;
  logic         res_push;
  logic         res_ok;
  back_status_t back_status;

  utf8v_front u_front (
    .data_byte_i (data_byte_i),
    .has_byte_i  (has_byte_i),
    .is_last_i   (is_last_i),
    .item_o      (in_item)
  );

  utf8v_fifo #(
    .Depth (QUEUE_DEPTH),
    .T     (item_t)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (in_item),
    .full_o  (full_o),
    .pop_i   (q_pop),
    .data_o  (q_item),
    .empty_o (q_empty)
  );

  utf8v_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (q_item),
    .item_valid_i (!q_empty),
    .item_pop_o   (q_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_ok_o     (res_ok),
    .status_o     (back_status)
  );

  utf8v_fifo #(
    .Depth (QUEUE_DEPTH),
    .T     (logic)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_ok),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (string_ok_o),
    .empty_o (empty_o)
  );

  // a verdict is never dropped on a full result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(res_push && res_full))
    else $error("verdict pushed into full result queue");

  // a verdict comes only from an end mark transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> q_item.is_last)
    else $error("verdict without end mark");

  // checker state is clear after every verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |=> back_status.idle)
    else $error("checker state not cleared after verdict");

  // a string with a failure seen can never be reported valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (res_push && back_status.failed) |-> !res_ok)
    else $error("failed string reported valid");

  // a bare end mark in the middle of a sequence reports the string invalid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (res_push && !q_item.has_byte && !back_status.pending_zero) |-> !res_ok)
    else $error("cut-off sequence reported valid");

endmodule : utf8_string_validator_top
`default_nettype wire

// File: tb/utf8_verdict_checker.sv
// ----------------------------------------------------------------------------
// utf8_verdict_checker
// Watches the byte and verdict channels of the utf-8 string validator, predicts
// the verdict of each string and compares it with what the block returns.
// ----------------------------------------------------------------------------
module utf8_verdict_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_push_i,
  input  logic        in_full_i,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        is_last_i,
  input  logic        res_pop_i,
  input  logic        res_empty_i,
  input  logic        string_ok_i,
  output logic [31:0] fail_count_o,
  output logic [31:0] outstanding_o
);
  import utf8v_pkg::*;

  // decoder state of the string under way
  logic        str_failed;
  logic [2:0]  cont_left;
  logic [2:0]  seq_len;
  logic [31:0] cp_acc;

  logic        verdict_q[$];
  int unsigned fails;

  // sequence length announced by a lead byte, 0 when it is no multi-byte lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    casez (b)
      8'b110?????: lead_length = 3'd2;
      8'b1110????: lead_length = 3'd3;
      8'b11110???: lead_length = 3'd4;
      8'b111110??: lead_length = 3'd5;
      8'b1111110?: lead_length = 3'd6;
      default:     lead_length = 3'd0;
    endcase
  endfunction

  function automatic lead_e classify(input logic [7:0] b);
    if (b == 8'h00) classify = LeadNul;
    else if (!b[7]) classify = LeadAscii;
    else if (lead_length(b) != 3'd0) classify = LeadMulti;
    else classify = LeadBad;
  endfunction

  function automatic logic [2:0] min_length(input logic [31:0] cp);
    if (cp < 32'h80) min_length = 3'd1;
    else if (cp < 32'h800) min_length = 3'd2;
    else if (cp < 32'h10000) min_length = 3'd3;
    else if (cp < 32'h200000) min_length = 3'd4;
    else if (cp < 32'h4000000) min_length = 3'd5;
    else min_length = 3'd6;
  endfunction

  function automatic logic is_scalar(input logic [31:0] cp);
    is_scalar = (cp < 32'h110000) && ((cp & 32'hFFFFF800) != 32'hD800);
  endfunction

  task automatic take_byte(input logic [7:0] b);
    logic [2:0] len;
    if (!str_failed) begin
      if (cont_left == 3'd0) begin
        case (classify(b))
          LeadNul, LeadBad: str_failed = 1'b1;
          LeadAscii: ;
          default: begin
            len       = lead_length(b);
            seq_len   = len;
            cont_left = len - 3'd1;
            cp_acc    = {24'd0, b & (8'hFF >> (len + 3'd1))};
          end
        endcase
      end else if (b[7:6] != 2'b10) begin
        str_failed = 1'b1;
      end else begin
        cp_acc    = {cp_acc[25:0], b[5:0]};
        cont_left = cont_left - 3'd1;
        if (cont_left == 3'd0) begin
          // overlong, out of range and surrogate forms all land here
          if (min_length(cp_acc) != seq_len || !is_scalar(cp_acc)) str_failed = 1'b1;
          seq_len = 3'd0;
          cp_acc  = 32'd0;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic want;
    if (!rst_ni) begin
      str_failed = 1'b0;
      cont_left  = 3'd0;
      seq_len    = 3'd0;
      cp_acc     = 32'd0;
      verdict_q.delete();
      fails      = 0;
      fail_count_o  <= 32'd0;
      outstanding_o <= 32'd0;
    end else begin
      // a verdict popped now was predicted before, when its end mark was taken
      if (res_pop_i && !res_empty_i) begin
        if (verdict_q.size() == 0) begin
          if (fails < 10) $display("unexpected verdict transaction: string_ok=%0b", string_ok_i);
          fails++;
        end else begin
          want = verdict_q.pop_front();
          if (string_ok_i !== want) begin
            if (fails < 10) begin
              $display("verdict mismatch: expected string_ok=%0b, got %0b", want, string_ok_i);
            end
            fails++;
          end
        end
      end
      if (in_push_i && !in_full_i) begin
        if (has_byte_i) take_byte(data_byte_i);
        if (is_last_i) begin
          verdict_q.push_back(!str_failed && cont_left == 3'd0);
          str_failed = 1'b0;
          cont_left  = 3'd0;
          seq_len    = 3'd0;
          cp_acc     = 32'd0;
        end
      end
      fail_count_o  <= fails;
      outstanding_o <= verdict_q.size();
    end
  end

endmodule : utf8_verdict_checker

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives strings of mostly well-formed utf-8 with injected faults into the
// validator, with random gaps on both channels; the checker scores verdicts.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned ItemTarget = 1700;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 10;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        push_i      = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        has_byte_i  = 1'b0;
  logic        is_last_i   = 1'b0;
  logic        pop_i       = 1'b0;
  logic        full_o;
  logic        empty_o;
  logic        string_ok_o;

  logic        steady = 1'b0;
  logic [31:0] fail_count;
  logic [31:0] outstanding;
  int unsigned sent  = 0;
  int unsigned quiet = 0;
  logic [7:0]  str_q[$];

  utf8_string_validator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .data_byte_i (data_byte_i),
    .has_byte_i  (has_byte_i),
    .is_last_i   (is_last_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .string_ok_o (string_ok_o)
  );

  utf8_verdict_checker verdict_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_push_i     (push_i),
    .in_full_i     (full_o),
    .data_byte_i   (data_byte_i),
    .has_byte_i    (has_byte_i),
    .is_last_i     (is_last_i),
    .res_pop_i     (pop_i),
    .res_empty_i   (empty_o),
    .string_ok_i   (string_ok_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side stalls about a quarter of the time outside the steady stretch
  always @(posedge clk_i) begin
    pop_i <= steady || ($urandom_range(99) >= 25);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push_i && !full_o) || (pop_i && !empty_o)) begin
      quiet <= 0;
    end else if (quiet == StallLimit) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic h, input logic l);
    while (!steady && $urandom_range(99) < 25) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i      <= 1'b1;
    data_byte_i <= b;
    has_byte_i  <= h;
    is_last_i   <= l;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    sent++;
  endtask

  // encode cp as an n byte sequence, whether or not n is its proper length
  task automatic push_code(input logic [31:0] cp, input int n);
    logic [7:0]  lead;
    logic [31:0] t;
    if (n == 1) begin
      str_q.push_back(cp[7:0]);
    end else begin
      lead = 8'hFF << (8 - n);
      t    = (cp >> (6 * (n - 1))) & (32'hFF >> (n + 1));
      str_q.push_back(lead | t[7:0]);
      for (int k = n - 2; k >= 0; k--) begin
        t = cp >> (6 * k);
        str_q.push_back({2'b10, t[5:0]});
      end
    end
  endtask

  task automatic add_char();
    int unsigned kind;
    logic [31:0] cp;
    logic [7:0]  b;
    int          n;
    kind = $urandom_range(99);
    n    = 0;
    if (kind < 40) begin
      cp = $urandom_range(32'h7F, 32'h01);
      n  = 1;
    end else if (kind < 55) begin
      cp = $urandom_range(32'h7FF, 32'h80);
      n  = 2;
    end else if (kind < 70) begin
      cp = $urandom_range(32'hFFFF, 32'h800);
      n  = 3;
    end else if (kind < 80) begin
      cp = $urandom_range(32'h10FFFF, 32'h10000);
      n  = 4;
    end else begin
      case ($urandom_range(7))
        0: begin
          // overlong: value below what the length needs
          n = $urandom_range(4, 2);
          case (n)
            2:       cp = $urandom_range(32'h7F, 32'h0);
            3:       cp = $urandom_range(32'h7FF, 32'h0);
            default: cp = $urandom_range(32'hFFFF, 32'h0);
          endcase
        end
        1: begin
          cp = $urandom_range(32'h1FFFFF, 32'h110000);
          n  = 4;
        end
        2: begin
          cp = $urandom_range(32'hDFFF, 32'hD800);
          n  = 3;
        end
        3: begin
          n  = $urandom_range(6, 5);
          cp = $urandom & ((n == 5) ? 32'h3FFFFFF : 32'h7FFFFFFF);
        end
        4: str_q.push_back(8'($urandom));
        5: str_q.push_back(8'h00);
        6: begin
          // truncated sequence
          push_code($urandom_range(32'h10FFFF, 32'h80), $urandom_range(4, 2));
          void'(str_q.pop_back());
        end
        default: begin
          push_code($urandom_range(32'hFFFF, 32'h800), 3);
          b = 8'($urandom);
          if (b[7:6] == 2'b10) b[7] = 1'b0;
          str_q[str_q.size() - 1] = b;
        end
      endcase
    end
    if (n != 0) push_code(cp, n);
  endtask

  // end mark rides on the last byte or comes as a bare end item
  task automatic send_string();
    int   n;
    logic bare;
    n    = str_q.size();
    bare = (n == 0) || ($urandom_range(1) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 5) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(str_q[i], 1'b1, !bare && (i == n - 1));
    end
    if (bare) send_item(8'($urandom), 1'b0, 1'b1);
    str_q.delete();
  endtask

  initial begin
    int   nchars;
    logic paused;
    paused = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty string
    send_item(8'hFF, 1'b0, 1'b1);
    // valid string with the top value of each short length
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'hDF, 1'b1, 1'b0);
    send_item(8'hBF, 1'b1, 1'b0);
    send_item(8'hEF, 1'b1, 1'b0);
    send_item(8'hBF, 1'b1, 1'b0);
    send_item(8'hBF, 1'b1, 1'b1);
    // nul byte
    send_item(8'h00, 1'b1, 1'b1);
    // bad lead, later byte ignored
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h41, 1'b1, 1'b1);
    // overlong two byte form
    send_item(8'hC0, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    // surrogate
    send_item(8'hED, 1'b1, 1'b0);
    send_item(8'hA0, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    // six byte form
    send_item(8'hFC, 1'b1, 1'b0);
    repeat (4) send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    // bad continuation after an idle item with no byte and no end
    send_item(8'hC2, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    // cut-off sequence
    send_item(8'hE0, 1'b1, 1'b0);
    send_item(8'hA0, 1'b1, 1'b0);
    send_item(8'hAA, 1'b0, 1'b1);

    while (sent < ItemTarget) begin
      steady <= (sent >= 400 && sent < 700);
      if (!paused && sent >= 850) begin
        // drain every pending verdict before going on
        push_i <= 1'b0;
        @(posedge clk_i);
        while (outstanding != 0) @(posedge clk_i);
        paused = 1'b1;
      end
      nchars = ($urandom_range(9) < 8) ? $urandom_range(4) : $urandom_range(12, 5);
      for (int i = 0; i < nchars; i++) add_char();
      send_string();
    end
    push_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule : tb_top

// File: filelist.f
sv/utf8v_pkg.sv
sv/utf8v_fifo.sv
sv/utf8v_front.sv
sv/utf8v_back.sv
sv/utf8_string_validator_top.sv
tb/utf8_verdict_checker.sv
tb/tb_top.sv
